### rtl/trzb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trzb_pkg
// Shared types, constants and helpers for the run-average zone bitmap block.
// ----------------------------------------------------------------------------
package trzb_pkg;

    localparam int MAX_SENSORS  = 8;
    localparam int CNT_W        = $clog2(MAX_SENSORS + 1);
    localparam int SUM_W        = 20;
    localparam int DIST_W       = 16;
    localparam int CFG_W        = 8;
    localparam int TEN_W        = 12;
    localparam int ZONE_COUNT   = 6;
    localparam int TENTHS       = 10;
    localparam logic [ZONE_COUNT-1:0] ZONE_MASK = 6'h3f;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int DIV_STEPS    = SUM_W;
    localparam int STEP_W       = $clog2(DIV_STEPS);
    localparam int ZONE_STEPS   = 7;
    localparam int Q_W          = 3;

    // configuration register indexes
    localparam logic CFG_OFFSET = 1'b0;
    localparam logic CFG_PITCH  = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] offset_mm;
        logic [CFG_W-1:0] pitch_mm;
    } t_cfg;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              valid;
        logic              last;
    } t_entry;

    typedef struct packed {
        logic [CNT_W-1:0] run_count;
        logic             load;
    } t_back_stat;

    // millimetres to tenths
    function automatic logic [TEN_W-1:0] times_ten(input logic [CFG_W-1:0] v);
        return TEN_W'(v) * TEN_W'(TENTHS);
    endfunction

    // one or two zone bits from the two quotients, indexes of six or more drop out
    function automatic logic [ZONE_COUNT-1:0] zone_bits(input logic [Q_W-1:0] q1,
                                                       input logic [Q_W-1:0] q2);
        logic [ZONE_COUNT-1:0] b;
        b = '0;
        for (int i = 0; i < ZONE_COUNT; i++) begin
            if (q1 == Q_W'(i) || q2 == Q_W'(i)) begin
                b[i] = 1'b1;
            end
        end
        return b & ZONE_MASK;
    endfunction

endpackage
`default_nettype wire

### rtl/trzb_smp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trzb_smp_if
// Sample channel: distance word with last-of-scan flag.
// ----------------------------------------------------------------------------
interface trzb_smp_if;
    logic                          valid;
    logic                          ready;
    logic [trzb_pkg::DIST_W-1:0]   distance;
    logic                          last_in_scan;

    modport source(output valid, output distance, output last_in_scan, input ready);
    modport sink(input valid, input distance, input last_in_scan, output ready);
endinterface
`default_nettype wire

### rtl/trzb_res_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trzb_res_if
// Result channel: zone bitmap of one scan.
// ----------------------------------------------------------------------------
interface trzb_res_if;
    logic                              valid;
    logic                              ready;
    logic [trzb_pkg::ZONE_COUNT-1:0]   zone_bitmap;

    modport source(output valid, output zone_bitmap, input ready);
    modport sink(input valid, input zone_bitmap, output ready);
endinterface
`default_nettype wire

### rtl/trzb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trzb_front
// Accepts samples and marks each one in or out of the zone window.
// ----------------------------------------------------------------------------
module trzb_front (
    input  wire trzb_pkg::t_cfg   i_cfg,
    trzb_smp_if.sink              i_smp,
    output logic                  o_push_valid,
    input  wire                   i_push_ready,
    output trzb_pkg::t_entry      o_push_data
);

    logic [trzb_pkg::TEN_W-1:0] lo;
    logic [14:0]                hi;
    logic [13:0]                span;
    logic                       in_window;

    always_comb begin
        lo   = trzb_pkg::times_ten(i_cfg.offset_mm);
        // six pitches in tenths: pitch * 60
        span = (14'(i_cfg.pitch_mm) << 6) - (14'(i_cfg.pitch_mm) << 2);
        hi   = 15'(lo) + 15'(span);
        in_window = (i_cfg.pitch_mm != '0)
                 && (i_smp.distance > trzb_pkg::DIST_W'(lo))
                 && (i_smp.distance < trzb_pkg::DIST_W'(hi));
    end

    assign o_push_valid         = i_smp.valid;
    assign i_smp.ready          = i_push_ready;
    assign o_push_data.distance = i_smp.distance;
    assign o_push_data.valid    = in_window;
    assign o_push_data.last     = i_smp.last_in_scan;

endmodule
`default_nettype wire

### rtl/trzb_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trzb_queue
// Short first-in first-out queue of classified samples.
// ----------------------------------------------------------------------------
module trzb_queue (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push_valid,
    output logic                  o_push_ready,
    input  wire trzb_pkg::t_entry i_push_data,
    output logic                  o_pop_valid,
    input  wire                   i_pop_ready,
    output trzb_pkg::t_entry      o_pop_data
);

    trzb_pkg::t_entry               r_mem [trzb_pkg::QUEUE_DEPTH];
    logic [trzb_pkg::QPTR_W-1:0]    r_wp, n_wp;
    logic [trzb_pkg::QPTR_W-1:0]    r_rp, n_rp;
    logic [trzb_pkg::QPTR_W:0]      r_cnt, n_cnt;
    logic                           push, pop;

    assign o_push_ready = (r_cnt != (trzb_pkg::QPTR_W + 1)'(trzb_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wp  = push ? r_wp + 1'b1 : r_wp;
        n_rp  = pop  ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule
`default_nettype wire

### rtl/trzb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trzb_back
// Run accumulation, iterative run average and zone mapping, scan output.
// ----------------------------------------------------------------------------
module trzb_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire trzb_pkg::t_cfg   i_cfg,
    input  wire                   i_pop_valid,
    output logic                  o_pop_ready,
    input  wire trzb_pkg::t_entry i_pop_data,
    trzb_res_if.source            o_res,
    output trzb_pkg::t_back_stat  o_stat
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_ZSET = 5'b00100,
        ST_ZONE = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    t_state                              r_state, n_state;
    logic [trzb_pkg::SUM_W-1:0]          r_sum, n_sum;
    logic [trzb_pkg::CNT_W-1:0]          r_count, n_count;
    logic [trzb_pkg::ZONE_COUNT-1:0]     r_bits, n_bits;
    logic                                r_last, n_last;
    logic [trzb_pkg::SUM_W-1:0]          r_dvd, n_dvd;
    logic [trzb_pkg::CNT_W-1:0]          r_rem, n_rem;
    logic [trzb_pkg::STEP_W-1:0]         r_step, n_step;
    logic [16:0]                         r_x1, n_x1;
    logic [16:0]                         r_x2, n_x2;
    logic [trzb_pkg::Q_W-1:0]            r_q1, n_q1;
    logic [trzb_pkg::Q_W-1:0]            r_q2, n_q2;
    logic                                r_zok, n_zok;
    logic                                r_out_valid, n_out_valid;
    logic [trzb_pkg::ZONE_COUNT-1:0]     r_out_bitmap, n_out_bitmap;

    logic [trzb_pkg::TEN_W-1:0]          o10, p10;
    logic                                take, add_ok, close_now, load;
    logic [trzb_pkg::SUM_W-1:0]          sum_after;
    logic [trzb_pkg::CNT_W-1:0]          cnt_after;
    logic [trzb_pkg::CNT_W:0]            trial;
    logic [trzb_pkg::DIST_W-1:0]         avg;

    assign o10         = trzb_pkg::times_ten(i_cfg.offset_mm);
    assign p10         = trzb_pkg::times_ten(i_cfg.pitch_mm);
    assign o_pop_ready = (r_state == ST_IDLE);
    assign take        = i_pop_valid && o_pop_ready;
    assign load        = (r_state == ST_OUT) && (!r_out_valid || o_res.ready);
    assign avg         = r_dvd[trzb_pkg::DIST_W-1:0];
    assign trial       = {r_rem, r_dvd[trzb_pkg::SUM_W-1]};

    always_comb begin
        add_ok    = i_pop_data.valid
                 && (r_count < trzb_pkg::CNT_W'(trzb_pkg::MAX_SENSORS));
        sum_after = add_ok ? r_sum + trzb_pkg::SUM_W'(i_pop_data.distance) : r_sum;
        cnt_after = add_ok ? r_count + 1'b1 : r_count;
        close_now = !i_pop_data.valid || i_pop_data.last;
    end

    always_comb begin
        n_state      = r_state;
        n_sum        = r_sum;
        n_count      = r_count;
        n_bits       = r_bits;
        n_last       = r_last;
        n_dvd        = r_dvd;
        n_rem        = r_rem;
        n_step       = r_step;
        n_x1         = r_x1;
        n_x2         = r_x2;
        n_q1         = r_q1;
        n_q2         = r_q2;
        n_zok        = r_zok;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_bitmap = r_out_bitmap;

        case (r_state)
            ST_IDLE: begin
                if (take) begin
                    n_last = i_pop_data.last;
                    if (close_now && cnt_after != '0) begin
                        n_sum   = sum_after;
                        n_count = cnt_after;
                        n_dvd   = sum_after;
                        n_rem   = '0;
                        n_step  = '0;
                        n_state = ST_DIV;
                    end else if (close_now) begin
                        n_sum   = '0;
                        n_count = '0;
                        if (i_pop_data.last) begin
                            n_state = ST_OUT;
                        end
                    end else begin
                        n_sum   = sum_after;
                        n_count = cnt_after;
                    end
                end
            end
            ST_DIV: begin
                // restoring divide, one quotient bit a step
                if (trial >= {1'b0, r_count}) begin
                    n_rem = trzb_pkg::CNT_W'(trial - {1'b0, r_count});
                    n_dvd = {r_dvd[trzb_pkg::SUM_W-2:0], 1'b1};
                end else begin
                    n_rem = trial[trzb_pkg::CNT_W-1:0];
                    n_dvd = {r_dvd[trzb_pkg::SUM_W-2:0], 1'b0};
                end
                n_step = r_step + 1'b1;
                if (r_step == trzb_pkg::STEP_W'(trzb_pkg::DIV_STEPS - 1)) begin
                    n_state = ST_ZSET;
                end
            end
            ST_ZSET: begin
                n_zok   = (p10 != '0) && (avg >= trzb_pkg::DIST_W'(o10));
                n_x1    = 17'(avg) - 17'(o10);
                n_x2    = 17'(avg) - 17'(o10) + 17'(p10 >> 1);
                n_q1    = '0;
                n_q2    = '0;
                n_step  = '0;
                n_state = ST_ZONE;
            end
            ST_ZONE: begin
                // quotient by repeated subtraction, saturating at seven
                if (r_x1 >= 17'(p10) && r_q1 != '1) begin
                    n_x1 = r_x1 - 17'(p10);
                    n_q1 = r_q1 + 1'b1;
                end
                if (r_x2 >= 17'(p10) && r_q2 != '1) begin
                    n_x2 = r_x2 - 17'(p10);
                    n_q2 = r_q2 + 1'b1;
                end
                n_step = r_step + 1'b1;
                if (r_step == trzb_pkg::STEP_W'(trzb_pkg::ZONE_STEPS - 1)) begin
                    if (r_zok) begin
                        n_bits = r_bits | trzb_pkg::zone_bits(n_q1, n_q2);
                    end
                    n_sum   = '0;
                    n_count = '0;
                    n_state = r_last ? ST_OUT : ST_IDLE;
                end
            end
            ST_OUT: begin
                if (load) begin
                    n_out_valid  = 1'b1;
                    n_out_bitmap = r_bits;
                    n_bits       = '0;
                    n_sum        = '0;
                    n_count      = '0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_count     <= '0;
            r_bits      <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_count     <= n_count;
            r_bits      <= n_bits;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd        <= n_dvd;
        r_rem        <= n_rem;
        r_step       <= n_step;
        r_x1         <= n_x1;
        r_x2         <= n_x2;
        r_q1         <= n_q1;
        r_q2         <= n_q2;
        r_zok        <= n_zok;
        r_out_bitmap <= n_out_bitmap;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.zone_bitmap = r_out_bitmap;
    assign o_stat.run_count  = r_count;
    assign o_stat.load       = load;

endmodule
`default_nettype wire

### rtl/tof_run_average_zone_bitmap.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tof_run_average_zone_bitmap
// Zone bitmap of a scan from runs of in-window distance words.
// ----------------------------------------------------------------------------
// Each distance word is checked against the zone window on entry and queued
// (four deep). The back end takes one word a cycle while it only extends a
// run or sees an empty one; a word that closes a non-empty run is popped,
// then goes through 20 steps of the bit-serial run-average divider, a zone
// set-up state and 7 steps of the zone quotient loop before the next word is
// taken. The last word of a scan also leads to a load of the bitmap into
// the output register, and that load waits for as long as the previous
// bitmap has not been taken. The output register holds the bitmap while
// further words are taken. Configuration takes effect at once.
module tof_run_average_zone_bitmap (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire                            i_cfg_idx,
    input  wire [trzb_pkg::CFG_W-1:0]      i_cfg_data,
    trzb_smp_if.sink                       i_smp,
    trzb_res_if.source                     o_res
);

    logic [trzb_pkg::CFG_W-1:0] r_offset, r_pitch;
    trzb_pkg::t_cfg             cfg;
    logic                       push_valid, push_ready;
    trzb_pkg::t_entry           push_data;
    logic                       pop_valid, pop_ready;
    trzb_pkg::t_entry           pop_data;
    trzb_pkg::t_back_stat       stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= 8'd10;
            r_pitch  <= 8'd20;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                trzb_pkg::CFG_OFFSET: r_offset <= i_cfg_data;
                trzb_pkg::CFG_PITCH:  r_pitch  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg.offset_mm = r_offset;
    assign cfg.pitch_mm  = r_pitch;

    trzb_front u_front (
        .i_cfg        (cfg),
        .i_smp        (i_smp),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    trzb_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    trzb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .o_res       (o_res),
        .o_stat      (stat)
    );

    // run never grows past the sensor limit
    a_run_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.run_count <= trzb_pkg::CNT_W'(trzb_pkg::MAX_SENSORS))
        else $error("run count above limit");

    // a fresh result only follows a bitmap load
    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(stat.load))
        else $error("result without bitmap load");

    // a word pushed into an empty queue is visible next cycle
    a_queue_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_valid && push_ready && !pop_valid) |=> pop_valid)
        else $error("queued word lost");

endmodule
`default_nettype wire
